// ===== sv/pd_pkg.sv =====
package pd_pkg;

  localparam int ByteW   = 8;
  localparam int GroupN  = 3;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [1:0]       cnt_t;

  // Held-character state codes
  localparam cnt_t PEND_NONE  = 2'd0;
  localparam cnt_t PEND_PCT   = 2'd1;
  localparam cnt_t PEND_DIGIT = 2'd2;

  localparam byte_t PERCENT_CHAR = 8'h25;
  localparam byte_t CHAR_0 = 8'h30;
  localparam byte_t CHAR_9 = 8'h39;
  localparam byte_t CHAR_LA = 8'h61;
  localparam byte_t CHAR_LF = 8'h66;
  localparam byte_t CHAR_UA = 8'h41;
  localparam byte_t CHAR_UF = 8'h46;
  localparam logic [3:0] ALPHA_BASE = 4'd10;

  // Result of decoding one input character against the held state
  typedef struct packed {
    cnt_t                 cnt;
    byte_t [GroupN-1:0]   bytes;
    logic                 last;
    cnt_t                 pend_nxt;
    byte_t                digit_nxt;
  } dec_t;

  function automatic logic hex_valid(input byte_t c);
    return (c >= CHAR_0 && c <= CHAR_9) || (c >= CHAR_LA && c <= CHAR_LF) ||
           (c >= CHAR_UA && c <= CHAR_UF);
  endfunction

  function automatic logic [3:0] hex_nibble(input byte_t c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= CHAR_0 && c <= CHAR_9) begin
      v = c[3:0];
    end else if ((c >= CHAR_LA && c <= CHAR_LF) || (c >= CHAR_UA && c <= CHAR_UF)) begin
      v = ALPHA_BASE + c[3:0] - 4'd1;
    end
    return v;
  endfunction

endpackage

// ===== sv/pd_in_if.sv =====
interface pd_in_if;
  logic                valid;
  logic                ready;
  logic [7:0]          in_byte;
  logic                in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== sv/pd_out_if.sv =====
interface pd_out_if;
  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  logic                out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

// ===== sv/pd_decode.sv =====
module pd_decode (
  input  pd_pkg::cnt_t  pend,
  input  pd_pkg::byte_t digit,
  input  pd_pkg::byte_t c,
  input  logic          last,
  output pd_pkg::dec_t  dec
);
  import pd_pkg::*;

  always_comb begin
    logic  hv;
    cnt_t  n;
    cnt_t  p;
    byte_t d;
    byte_t [GroupN-1:0] b;

    hv = hex_valid(c);
    n  = 2'd0;
    p  = PEND_NONE;
    d  = digit;
    b  = '0;

    case (pend)
      PEND_PCT: begin
        if (hv) begin
          p = PEND_DIGIT;
          d = c;
        end else begin
          b[n] = PERCENT_CHAR;
          n = n + 2'd1;
          if (c == PERCENT_CHAR) begin
            p = PEND_PCT;
          end else begin
            b[n] = c;
            n = n + 2'd1;
          end
        end
      end
      PEND_DIGIT: begin
        if (hv) begin
          b[n] = {hex_nibble(digit), hex_nibble(c)};
          n = n + 2'd1;
        end else begin
          b[n] = PERCENT_CHAR;
          n = n + 2'd1;
          b[n] = digit;
          n = n + 2'd1;
          if (c == PERCENT_CHAR) begin
            p = PEND_PCT;
          end else begin
            b[n] = c;
            n = n + 2'd1;
          end
        end
      end
      default: begin
        if (c == PERCENT_CHAR) begin
          p = PEND_PCT;
        end else begin
          b[n] = c;
          n = n + 2'd1;
        end
      end
    endcase

    // flush anything still held at end of string
    if (last) begin
      if (p == PEND_PCT || p == PEND_DIGIT) begin
        b[n] = PERCENT_CHAR;
        n = n + 2'd1;
      end
      if (p == PEND_DIGIT) begin
        b[n] = d;
        n = n + 2'd1;
      end
      p = PEND_NONE;
    end

    dec.cnt       = n;
    dec.bytes     = b;
    dec.last      = last;
    dec.pend_nxt  = p;
    dec.digit_nxt = d;
  end

endmodule

// ===== sv/percent_decoder.sv =====
// Streaming URI percent-escape decoder. Each input transaction carries one
// raw character and a last flag; "%hh" (either hex case) turns into one
// byte, a broken escape goes out literally and the characters after it are
// scanned afresh, and on the last character anything still held ('%' and
// possibly one digit) is flushed literally with out_last on the final byte.
// An input character yields zero to three output bytes. The decode is one
// combinational pass from the held state and the incoming character into a
// three-entry result register, which drains one byte per cycle while the
// output is ready. Rate: one character per cycle while each produces at most
// one byte and the output is ready; a character producing k bytes (k = 2 or 3)
// holds the result register until they drain, so input ready returns as its
// last byte is taken. The first output byte is offered in the cycle after the character is accepted.
module percent_decoder (
  input  logic clk,
  input  logic rst_n,
  pd_in_if.sink    in_ch,
  pd_out_if.source out_ch
);
  import pd_pkg::*;

  // held-escape state
  cnt_t  pend_r, pend_nxt;
  byte_t digit_r, digit_nxt;

  // result group: bytes, fill length, read position, last flag
  byte_t [GroupN-1:0] grp_r, grp_nxt;
  cnt_t  len_r, len_nxt;
  cnt_t  pos_r, pos_nxt;
  logic  last_r, last_nxt;

  dec_t  dec;
  logic  in_fire;
  logic  out_fire;
  logic  grp_done;
  cnt_t  pos_inc;

  pd_decode u_decode (
    .pend  (pend_r),
    .digit (digit_r),
    .c     (in_ch.in_byte),
    .last  (in_ch.in_last),
    .dec   (dec)
  );

  assign pos_inc  = pos_r + 2'd1;
  assign grp_done = (pos_inc == len_r);

  // accept while the group is empty or its final byte leaves this cycle
  assign in_ch.ready = (len_r == 2'd0) || (out_ch.ready && grp_done);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid = (len_r != 2'd0);
  assign out_fire     = out_ch.valid && out_ch.ready;

  always_comb begin
    case (pos_r)
      2'd0:    out_ch.out_byte = grp_r[0];
      2'd1:    out_ch.out_byte = grp_r[1];
      2'd2:    out_ch.out_byte = grp_r[2];
      default: out_ch.out_byte = grp_r[0];
    endcase
  end

  // last flag marks only the closing byte of the final group
  assign out_ch.out_last = last_r && grp_done;

  always_comb begin
    pend_nxt  = pend_r;
    digit_nxt = digit_r;
    grp_nxt   = grp_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    last_nxt  = last_r;
    if (out_fire) begin
      // advance through the group, drop it after its final byte
      if (grp_done) begin
        len_nxt = 2'd0;
        pos_nxt = 2'd0;
      end else begin
        pos_nxt = pos_inc;
      end
    end
    if (in_fire) begin
      pend_nxt  = dec.pend_nxt;
      digit_nxt = dec.digit_nxt;
      grp_nxt   = dec.bytes;
      len_nxt   = dec.cnt;
      pos_nxt   = 2'd0;
      last_nxt  = dec.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r  <= PEND_NONE;
      digit_r <= '0;
      len_r   <= 2'd0;
      pos_r   <= 2'd0;
    end else begin
      pend_r  <= pend_nxt;
      digit_r <= digit_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // payload: hold until reloaded
  always_ff @(posedge clk) begin
    grp_r  <= grp_nxt;
    last_r <= last_nxt;
  end

`ifndef ASSERT_OFF
  a_pos_in_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (pos_r < len_r))
    else $error("read position outside result group");

  a_pend_legal: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("illegal held-character count");

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.in_last) |=> (pend_r == PEND_NONE))
    else $error("held characters survive end of string");

  a_group_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !grp_done) |=> out_ch.valid)
    else $error("result group dropped before its final byte");
`endif

endmodule
